// ===== src/pstuq_pkg.sv =====
// shared types and constants for the prefix sum tree block
package pstuq_pkg;

	localparam int IDX_W = 11;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;

	localparam logic MODE_SET = 1'b0;
	localparam logic MODE_QRY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_RD,
		ST_SET_DIF,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_QRY_RD,
		ST_QRY_ACC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic req_valid;
		logic is_query;
		logic set_ok;
		logic clr_last;
		logic idx_zero;
		logic lo_phase;
		logic upd_last;
		logic rsp_free;
	} stat_t;

	typedef struct packed {
		logic ready;
		logic load_item;
		logic clr_we;
		logic val_we;
		logic delta_en;
		logic tree_we;
		logic idx_up;
		logic idx_dn;
		logic lo_load;
		logic acc_en;
		logic rsp_load;
	} ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
		logic             sub;
	} alu_req_t;

endpackage

// ===== src/pstuq_ifs.sv =====
// request and response channel interfaces
interface pstuq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [pstuq_pkg::IDX_W-1:0]       index_a;
	logic [pstuq_pkg::IDX_W-1:0]       index_b;
	logic signed [pstuq_pkg::VAL_W-1:0] new_value;

	modport source(output valid, mode, index_a, index_b, new_value, input ready);
	modport sink(input valid, mode, index_a, index_b, new_value, output ready);
endinterface

interface pstuq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [pstuq_pkg::SUM_W-1:0] range_sum;

	modport source(output valid, range_sum, input ready);
	modport sink(input valid, range_sum, output ready);
endinterface

// ===== src/prefix_sum_tree_update_query.sv =====
// top level of the binary indexed tree range sum block
// a request on req is a set (mode 0) or a range query (mode 1); only a query gives a
// response on rsp, carrying the signed 64-bit sum of values index_a to index_b.
// req.ready is high only while the sequencer is idle: one request is worked at a time.
// every tree node takes a read step and then an add or write step, through a single
// 64-bit add/subtract unit and the registered read port of the node ram.
// a set writes the new value and adds its difference to the u nodes on its update path
// (at most log2(NUM_ENTRIES) + 1); a set at index zero or past NUM_ENTRIES is dropped.
// a query walks the h and l nodes on the two prefix paths, upper path first, and
// subtracts the lower prefix sum from the upper one.
// the result waits in an output register, so the next request is taken while it is
// unread; a query that finishes while the register is still full holds until rsp.ready.
// after arst_n the block sweeps both rams to zero, one entry a cycle, over entries
// 0 to NUM_ENTRIES, with req.ready low; then all values read as zero.
module prefix_sum_tree_update_query #(
	parameter int NUM_ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	pstuq_req_if.sink           req,
	pstuq_rsp_if.source         rsp
);

	localparam int DEPTH = NUM_ENTRIES + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = AW + 1;
	localparam int CW    = AW + pstuq_pkg::IDX_W + 1;
	localparam logic [CW-1:0] N_C  = CW'(NUM_ENTRIES);
	localparam logic [IW-1:0] N_IW = IW'(NUM_ENTRIES);

	pstuq_pkg::stat_t    stat;
	pstuq_pkg::ctl_t     ctl;
	pstuq_pkg::alu_req_t alu_req;
	logic [pstuq_pkg::SUM_W-1:0] alu_sum;

	logic [AW-1:0] clr_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] lo_q;
	logic          phase_q;
	logic signed [pstuq_pkg::VAL_W-1:0] nv_q;
	logic [pstuq_pkg::SUM_W-1:0] delta_q;
	logic [pstuq_pkg::SUM_W-1:0] acc_q;
	logic [pstuq_pkg::SUM_W-1:0] sum_q;
	logic          rsp_valid_q;

	logic [CW-1:0] ia_ext;
	logic [CW-1:0] ib_ext;
	logic [CW-1:0] lo_ext;
	logic [IW-1:0] hi_idx;
	logic [IW-1:0] lo_idx;
	logic [IW-1:0] low_bit;
	logic [IW-1:0] idx_up_n;

	logic [AW-1:0] ram_raddr;
	logic [AW-1:0] ram_waddr;
	logic          tree_we;
	logic          val_we;
	logic [pstuq_pkg::SUM_W-1:0] tree_wdata;
	logic [pstuq_pkg::VAL_W-1:0] val_wdata;
	logic [pstuq_pkg::SUM_W-1:0] tree_rdata;
	logic [pstuq_pkg::VAL_W-1:0] val_rdata;

	// request decode and index clamping
	assign ia_ext = CW'(req.index_a);
	assign ib_ext = CW'(req.index_b);
	assign lo_ext = (req.index_a == '0) ? '0 : ia_ext - CW'(1);
	assign hi_idx = (ib_ext > N_C) ? IW'(N_C) : IW'(ib_ext);
	assign lo_idx = (lo_ext > N_C) ? IW'(N_C) : IW'(lo_ext);

	// tree walk steps
	assign low_bit  = idx_q & (~idx_q + IW'(1));
	assign idx_up_n = idx_q + low_bit;

	assign stat.req_valid = req.valid;
	assign stat.is_query  = (req.mode == pstuq_pkg::MODE_QRY);
	assign stat.set_ok    = (req.index_a != '0) && (ia_ext <= N_C);
	assign stat.clr_last  = (clr_q == AW'(NUM_ENTRIES));
	assign stat.idx_zero  = (idx_q == '0);
	assign stat.lo_phase  = phase_q;
	assign stat.upd_last  = (idx_up_n > N_IW);
	assign stat.rsp_free  = !rsp_valid_q || rsp.ready;

	pstuq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// operand selection for the shared adder
	always_comb begin
		if (ctl.acc_en) begin
			alu_req.a   = acc_q;
			alu_req.b   = tree_rdata;
			alu_req.sub = phase_q;
		end else if (ctl.delta_en) begin
			alu_req.a   = pstuq_pkg::SUM_W'(nv_q);
			alu_req.b   = pstuq_pkg::SUM_W'($signed(val_rdata));
			alu_req.sub = 1'b1;
		end else begin
			alu_req.a   = tree_rdata;
			alu_req.b   = delta_q;
			alu_req.sub = 1'b0;
		end
	end

	pstuq_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	assign ram_raddr  = idx_q[AW-1:0];
	assign ram_waddr  = ctl.clr_we ? clr_q : idx_q[AW-1:0];
	assign tree_we    = ctl.clr_we || ctl.tree_we;
	assign val_we     = ctl.clr_we || ctl.val_we;
	assign tree_wdata = ctl.clr_we ? '0 : alu_sum;
	assign val_wdata  = ctl.clr_we ? '0 : nv_q;

	pstuq_ram #(
		.WIDTH (pstuq_pkg::SUM_W),
		.DEPTH (DEPTH)
	) u_tree_ram (
		.clk   (clk),
		.we    (tree_we),
		.waddr (ram_waddr),
		.wdata (tree_wdata),
		.raddr (ram_raddr),
		.rdata (tree_rdata)
	);

	pstuq_ram #(
		.WIDTH (pstuq_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (ram_waddr),
		.wdata (val_wdata),
		.raddr (ram_raddr),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			idx_q       <= '0;
			phase_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_we && !stat.clr_last) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctl.load_item) begin
				idx_q   <= stat.is_query ? hi_idx : IW'(ia_ext);
				phase_q <= 1'b0;
			end else if (ctl.lo_load) begin
				idx_q   <= lo_q;
				phase_q <= 1'b1;
			end else if (ctl.idx_up) begin
				idx_q <= idx_up_n;
			end else if (ctl.idx_dn) begin
				idx_q <= idx_q - low_bit;
			end
			if (ctl.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			lo_q  <= lo_idx;
			nv_q  <= req.new_value;
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= alu_sum;
		end
		if (ctl.delta_en) begin
			delta_q <= alu_sum;
		end
		if (ctl.rsp_load) begin
			sum_q <= acc_q;
		end
	end

	assign req.ready     = ctl.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.range_sum = sum_q;

endmodule

// ===== src/pstuq_ram.sv =====
// generic single write port ram with registered read
module pstuq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/pstuq_alu.sv =====
// shared 64-bit add and subtract unit
module pstuq_alu (
	input  pstuq_pkg::alu_req_t              req,
	output logic [pstuq_pkg::SUM_W-1:0]      sum
);

	logic [pstuq_pkg::SUM_W-1:0] b_op;

	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = req.a + b_op + pstuq_pkg::SUM_W'(req.sub);

endmodule

// ===== src/pstuq_ctrl.sv =====
// sequencer for clear, set walk and query walks
module pstuq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  pstuq_pkg::stat_t  stat,
	output pstuq_pkg::ctl_t   ctl
);

	pstuq_pkg::state_t state_q;
	pstuq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pstuq_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pstuq_pkg::ST_CLEAR: begin
				if (stat.clr_last) state_d = pstuq_pkg::ST_IDLE;
			end
			pstuq_pkg::ST_IDLE: begin
				if (stat.req_valid) begin
					if (stat.is_query) state_d = pstuq_pkg::ST_QRY_RD;
					else if (stat.set_ok) state_d = pstuq_pkg::ST_SET_RD;
				end
			end
			pstuq_pkg::ST_SET_RD:  state_d = pstuq_pkg::ST_SET_DIF;
			pstuq_pkg::ST_SET_DIF: state_d = pstuq_pkg::ST_UPD_RD;
			pstuq_pkg::ST_UPD_RD:  state_d = pstuq_pkg::ST_UPD_WR;
			pstuq_pkg::ST_UPD_WR: begin
				state_d = stat.upd_last ? pstuq_pkg::ST_IDLE : pstuq_pkg::ST_UPD_RD;
			end
			pstuq_pkg::ST_QRY_RD: begin
				if (!stat.idx_zero) state_d = pstuq_pkg::ST_QRY_ACC;
				else if (stat.lo_phase) state_d = pstuq_pkg::ST_RESP;
			end
			pstuq_pkg::ST_QRY_ACC: state_d = pstuq_pkg::ST_QRY_RD;
			pstuq_pkg::ST_RESP: begin
				if (stat.rsp_free) state_d = pstuq_pkg::ST_IDLE;
			end
			default: state_d = pstuq_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			pstuq_pkg::ST_CLEAR: ctl.clr_we = 1'b1;
			pstuq_pkg::ST_IDLE: begin
				ctl.ready     = 1'b1;
				ctl.load_item = stat.req_valid;
			end
			pstuq_pkg::ST_SET_RD: ctl = '0;
			pstuq_pkg::ST_SET_DIF: begin
				ctl.val_we   = 1'b1;
				ctl.delta_en = 1'b1;
			end
			pstuq_pkg::ST_UPD_RD: ctl = '0;
			pstuq_pkg::ST_UPD_WR: begin
				ctl.tree_we = 1'b1;
				ctl.idx_up  = 1'b1;
			end
			pstuq_pkg::ST_QRY_RD: ctl.lo_load = stat.idx_zero && !stat.lo_phase;
			pstuq_pkg::ST_QRY_ACC: begin
				ctl.acc_en = 1'b1;
				ctl.idx_dn = 1'b1;
			end
			pstuq_pkg::ST_RESP: ctl.rsp_load = stat.rsp_free;
			default: ctl = '0;
		endcase
	end

endmodule

// ===== dv/pstuq_sum_checker.sv =====
// range sum checker: mirrors the binary indexed tree and compares every response
`timescale 1ns / 1ps
module pstuq_sum_checker #(
	parameter int NUM_ENTRIES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	pstuq_req_if req,
	pstuq_rsp_if rsp,
	output int   fail_count,
	output int   waiting
);

	logic [pstuq_pkg::SUM_W-1:0] node_sum [0:NUM_ENTRIES];
	logic [pstuq_pkg::VAL_W-1:0] stored   [0:NUM_ENTRIES];
	logic [pstuq_pkg::SUM_W-1:0] sums_due [$];
	logic [pstuq_pkg::SUM_W-1:0] want;
	int                          errs = 0;

	function automatic int unsigned lsb_of(input int unsigned k);
		return k & (~k + 1);
	endfunction

	function automatic logic [pstuq_pkg::SUM_W-1:0] prefix_total(input int unsigned upto);
		logic [pstuq_pkg::SUM_W-1:0] acc;
		int unsigned                 k;
		acc = '0;
		k = (upto > NUM_ENTRIES) ? NUM_ENTRIES : upto;
		while (k > 0) begin
			acc += node_sum[k];
			k -= lsb_of(k);
		end
		return acc;
	endfunction

	function automatic logic [pstuq_pkg::SUM_W-1:0] range_total(input int unsigned lo,
			input int unsigned hi);
		logic [pstuq_pkg::SUM_W-1:0] below;
		below = (lo == 0) ? '0 : prefix_total(lo - 1);
		return prefix_total(hi) - below;
	endfunction

	function automatic void store_value(input int unsigned idx,
			input logic [pstuq_pkg::VAL_W-1:0] val);
		logic [pstuq_pkg::SUM_W-1:0] delta;
		int unsigned                 k;
		if (idx == 0 || idx > NUM_ENTRIES)
			return;
		delta = {{(pstuq_pkg::SUM_W-pstuq_pkg::VAL_W){val[pstuq_pkg::VAL_W-1]}}, val}
			- {{(pstuq_pkg::SUM_W-pstuq_pkg::VAL_W){stored[idx][pstuq_pkg::VAL_W-1]}},
				stored[idx]};
		stored[idx] = val;
		k = idx;
		while (k <= NUM_ENTRIES) begin
			node_sum[k] += delta;
			k += lsb_of(k);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NUM_ENTRIES; k++) begin
				node_sum[k] = '0;
				stored[k] = '0;
			end
			sums_due.delete();
			errs = 0;
			fail_count <= 0;
			waiting <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (sums_due.size() == 0) begin
					errs++;
					$display("%0t: range_sum with no query pending, expected none, actual %0d",
						$time, $signed(rsp.range_sum));
				end else begin
					want = sums_due.pop_front();
					if (rsp.range_sum !== want) begin
						errs++;
						$display("%0t: range_sum mismatch, expected %0d, actual %0d",
							$time, $signed(want), $signed(rsp.range_sum));
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.mode == pstuq_pkg::MODE_QRY)
					sums_due.push_back(range_total(32'(req.index_a), 32'(req.index_b)));
				else
					store_value(32'(req.index_a), req.new_value);
			end
			fail_count <= errs;
			waiting <= sums_due.size();
		end
	end

endmodule

// ===== dv/tb_prefix_sum_tree_update_query.sv =====
// top of the prefix sum tree testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module tb_prefix_sum_tree_update_query;

	typedef logic [pstuq_pkg::IDX_W-1:0] idx_t;
	typedef logic [pstuq_pkg::VAL_W-1:0] val_t;

	localparam int   NUM_ENTRIES  = 1024;
	localparam int   RANDOM_REQS  = 1080;
	localparam int   CALM_REQS    = 150;
	localparam int   IDLE_LIMIT   = 4000;
	localparam int   DRAIN_CYCLES = 60;
	localparam idx_t N_IDX        = idx_t'(NUM_ENTRIES);

	logic clk;
	logic arst_n;
	int   fail_count;
	int   waiting;
	int   idle_cycles = 0;
	int   req_idle_pct = 0;
	int   rsp_idle_pct = 0;

	pstuq_req_if req_ch();
	pstuq_rsp_if rsp_ch();

	prefix_sum_tree_update_query #(.NUM_ENTRIES(NUM_ENTRIES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	pstuq_sum_checker #(.NUM_ENTRIES(NUM_ENTRIES)) sum_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < rsp_idle_pct) begin
				stall = $urandom_range(1, 19);
				rsp_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("prefix_sum_tree_update_query regression: fail");
			$finish;
		end
	end

	function automatic idx_t pick_index();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			return idx_t'($urandom_range(1, NUM_ENTRIES));
		else if (roll < 90)
			return '0;
		else
			return idx_t'($urandom_range(0, (1 << pstuq_pkg::IDX_W) - 1));
	endfunction

	function automatic val_t pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom;
		else if (roll < 90)
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return '0;
				default: return '1;
			endcase
		else
			return $urandom_range(0, 200) - 100;
	endfunction

	task automatic send_req(input logic m, input idx_t a, input idx_t b, input val_t v);
		int gap;
		if ($urandom_range(0, 99) < req_idle_pct) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.mode = m;
		req_ch.index_a = a;
		req_ch.index_b = b;
		req_ch.new_value = v;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic set_at(input idx_t idx, input val_t val);
		send_req(pstuq_pkg::MODE_SET, idx,
			idx_t'($urandom_range(0, (1 << pstuq_pkg::IDX_W) - 1)), val);
	endtask

	task automatic query_range(input idx_t lo, input idx_t hi);
		send_req(pstuq_pkg::MODE_QRY, lo, hi, $urandom);
	endtask

	initial begin
		idx_t lo_idx;
		idx_t hi_idx;
		idx_t swap_idx;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = pstuq_pkg::MODE_SET;
		req_ch.index_a = '0;
		req_ch.index_b = '0;
		req_ch.new_value = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edges of the index range, extreme values, ignored sets, reversed and clipped bounds
		query_range(idx_t'(1), N_IDX);
		set_at(idx_t'(1), 32'h7fff_ffff);
		set_at(N_IDX, 32'h8000_0000);
		set_at(N_IDX >> 1, '1);
		set_at('0, 32'h1234_5678);
		set_at(N_IDX + idx_t'(1), 32'h7fff_ffff);
		set_at('1, 32'h8000_0000);
		set_at(N_IDX - idx_t'(1), 32'h5555_5555);
		set_at(idx_t'(2), 32'haaaa_aaaa);
		query_range(idx_t'(1), N_IDX);
		query_range(idx_t'(1), idx_t'(1));
		query_range(N_IDX, N_IDX);
		query_range('0, N_IDX);
		query_range('0, '0);
		query_range(N_IDX, '1);
		query_range('1, '1);
		query_range(idx_t'(600), idx_t'(3));
		query_range(idx_t'(1), N_IDX - idx_t'(1));
		set_at(idx_t'(1), 32'h8000_0000);
		set_at(N_IDX, 32'h7fff_ffff);
		query_range(idx_t'(1), N_IDX);
		set_at(N_IDX >> 1, '0);
		query_range((N_IDX >> 1) - idx_t'(1), (N_IDX >> 1) + idx_t'(1));
		query_range(N_IDX + idx_t'(1), idx_t'(1));

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: req_idle_pct = 0;
					1: req_idle_pct = 8;
					default: req_idle_pct = 30;
				endcase
				case ($urandom_range(0, 2))
					0: rsp_idle_pct = 0;
					1: rsp_idle_pct = 8;
					default: rsp_idle_pct = 30;
				endcase
			end
			if (n >= RANDOM_REQS - CALM_REQS) begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			if ($urandom_range(0, 99) < 45) begin
				lo_idx = pick_index();
				hi_idx = pick_index();
				if (lo_idx > hi_idx && $urandom_range(0, 99) < 70) begin
					swap_idx = lo_idx;
					lo_idx = hi_idx;
					hi_idx = swap_idx;
				end
				query_range(lo_idx, hi_idx);
			end else begin
				set_at(pick_index(), pick_value());
			end
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("prefix_sum_tree_update_query regression: pass");
		end else begin
			$display("prefix_sum_tree_update_query regression: fail");
		end
		$finish;
	end

endmodule
